@@ sv/wcm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcm_pkg
// Shared widths, codes, command/status types and helpers for the wall column
// texture mapper.
// ----------------------------------------------------------------------------
package wcm_pkg;

    // Field widths
    localparam int COL_W   = 10;
    localparam int ROW_W   = 11;
    localparam int OROW_W  = 10;
    localparam int TEX_W   = 3;
    localparam int TXL_W   = 12;
    localparam int DIR_W   = 19;
    localparam int DIST_W  = 24;
    localparam int LH_W    = 16;
    localparam int POSIN_W = 24;
    localparam int SIZE_W  = 13;
    localparam int CFG_IDX_W = 1;

    // Internal arithmetic widths
    localparam int FRAC_W  = 16;
    localparam int OFS_W   = 16;
    localparam int POS_W   = 28;   // texture position, always below 4096 << 16
    localparam int STEP_W  = 29;   // row step, at most 4096 << 16
    localparam int BIG_W   = OFS_W + STEP_W;
    localparam int DIV_W   = 29;   // dividend / quotient width
    localparam int DVS_W   = 16;   // divisor / remainder width
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Screen geometry
    localparam int SCREEN_HEIGHT = 1024;
    localparam logic [ROW_W-1:0] SCREEN_ROWS = ROW_W'(SCREEN_HEIGHT);
    localparam logic [OFS_W-1:0] HALF_ROWS   = OFS_W'(SCREEN_HEIGHT / 2);

    // Texture sizes
    localparam logic [SIZE_W-1:0] MAX_SIZE       = SIZE_W'(4096);
    localparam logic [SIZE_W-1:0] TEX_SIZE_RESET = SIZE_W'(64);

    // Item commands
    localparam logic CMD_SETUP = 1'b0;
    localparam logic CMD_ROW   = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_W = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_H = 1'b1;

    // Texture indexes
    localparam logic [TEX_W-1:0] TEX_DOOR  = 3'd0;
    localparam logic [TEX_W-1:0] TEX_NORTH = 3'd1;
    localparam logic [TEX_W-1:0] TEX_SOUTH = 3'd2;
    localparam logic [TEX_W-1:0] TEX_EAST  = 3'd3;
    localparam logic [TEX_W-1:0] TEX_WEST  = 3'd4;

    // Divider operand select
    typedef enum logic [1:0] {
        DIV_STEP = 2'd0,
        DIV_POS  = 2'd1,
        DIV_TEX  = 2'd2,
        DIV_SUM  = 2'd3
    } t_div_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic     load_in;
        logic     su_mul;
        logic     su_frac;
        logic     su_tx;
        logic     div_start;
        t_div_sel div_sel;
        logic     step_cap;
        logic     ofs_mul;
        logic     su_commit;
        logic     row_sum;
        logic     tex_cap;
        logic     pos_red;
        logic     out_load;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
        logic span_active;
        logic tex_fast;
        logic red_fast;
        logic out_free;
    } t_dp_status;

    // Register value 0 acts as 1, values past 4096 act as 4096
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > MAX_SIZE) begin
            r = MAX_SIZE;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ sv/wcm_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcm_div
// Restoring radix-2 divider, one quotient bit per cycle. Gives quotient and
// remainder of a 29-bit dividend by a 16-bit divisor.
// ----------------------------------------------------------------------------
module wcm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [wcm_pkg::DIV_W-1:0]     i_dividend,
    input  logic [wcm_pkg::DVS_W-1:0]     i_divisor,
    output logic                          o_done,
    output logic [wcm_pkg::DIV_W-1:0]     o_quot,
    output logic [wcm_pkg::DVS_W-1:0]     o_rem
);
    import wcm_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_quot;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_divisor;

    logic [DVS_W:0]       rem_sh;
    logic                 rem_ge;
    logic [DVS_W:0]       rem_diff;
    logic [DVS_W-1:0]     n_rem;

    // Shift in the next dividend bit and trial-subtract
    assign rem_sh   = {r_rem, r_quot[DIV_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, r_divisor});
    assign rem_diff = rem_sh - {1'b0, r_divisor};
    assign n_rem    = rem_ge ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];

    // Iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Quotient / remainder shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIV_W-2:0], rem_ge};
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

@@ sv/wcm_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcm_datapath
// Registers, multipliers, shared divider and output register of the texture
// mapper. Bar size writes and output drain, acts only on controller commands.
// ----------------------------------------------------------------------------
module wcm_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  wcm_pkg::t_dp_cmd                     i_ctl,
    output wcm_pkg::t_dp_status                  o_status,
    // register writes
    input  logic                                 i_cfg_we,
    input  logic [wcm_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [wcm_pkg::SIZE_W-1:0]           i_cfg_data,
    // input item fields
    input  logic [wcm_pkg::COL_W-1:0]            i_column,
    input  logic                                 i_side,
    input  logic                                 i_is_door,
    input  logic signed [wcm_pkg::DIR_W-1:0]     i_ray_dir_x,
    input  logic signed [wcm_pkg::DIR_W-1:0]     i_ray_dir_y,
    input  logic [wcm_pkg::DIST_W-1:0]           i_wall_dist,
    input  logic [wcm_pkg::LH_W-1:0]             i_line_height,
    input  logic [wcm_pkg::ROW_W-1:0]            i_row_start,
    input  logic [wcm_pkg::ROW_W-1:0]            i_row_end,
    input  logic [wcm_pkg::POSIN_W-1:0]          i_player_x,
    input  logic [wcm_pkg::POSIN_W-1:0]          i_player_y,
    // result channel
    input  logic                                 i_stall,
    output logic                                 o_valid,
    output logic [wcm_pkg::COL_W-1:0]            o_out_column,
    output logic [wcm_pkg::OROW_W-1:0]           o_out_row,
    output logic [wcm_pkg::TEX_W-1:0]            o_texture_index,
    output logic [wcm_pkg::TXL_W-1:0]            o_texel_column,
    output logic [wcm_pkg::TXL_W-1:0]            o_texel_row,
    output logic                                 o_last
);
    import wcm_pkg::*;

    // Texture size registers
    logic [SIZE_W-1:0] r_tex_w;
    logic [SIZE_W-1:0] r_tex_h;
    logic [SIZE_W-1:0] tw;
    logic [SIZE_W-1:0] th;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_w <= TEX_SIZE_RESET;
            r_tex_h <= TEX_SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TEX_W: r_tex_w <= i_cfg_data;
                CFG_TEX_H: r_tex_h <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    assign tw = eff_size(r_tex_w);
    assign th = eff_size(r_tex_h);

    // Texture choice from door flag, side and direction signs
    logic             dx_pos;
    logic             dy_pos;
    logic             dy_neg;
    logic [TEX_W-1:0] in_tex;
    logic             in_flip;
    logic [LH_W-1:0]  in_lh;
    logic [OFS_W-1:0] ofs_sum;
    logic [OFS_W-1:0] in_ofs;

    assign dx_pos = !i_ray_dir_x[DIR_W-1] && (i_ray_dir_x != '0);
    assign dy_pos = !i_ray_dir_y[DIR_W-1] && (i_ray_dir_y != '0);
    assign dy_neg = i_ray_dir_y[DIR_W-1];

    always_comb begin
        if (i_is_door) begin
            in_tex = TEX_DOOR;
        end else if (i_side && dy_neg) begin
            in_tex = TEX_NORTH;
        end else if (i_side && dy_pos) begin
            in_tex = TEX_SOUTH;
        end else if (!i_side && dx_pos) begin
            in_tex = TEX_EAST;
        end else begin
            in_tex = TEX_WEST;
        end
    end

    assign in_flip = (!i_side && dx_pos) || (i_side && dy_neg);

    // Zero line height acts as one; start offset saturates at zero
    assign in_lh   = (i_line_height == '0) ? LH_W'(1) : i_line_height;
    assign ofs_sum = OFS_W'(i_row_start) + OFS_W'(in_lh[LH_W-1:1]);
    assign in_ofs  = (ofs_sum >= HALF_ROWS) ? (ofs_sum - HALF_ROWS) : '0;

    // Staged set-up fields
    logic [COL_W-1:0]         r_in_column;
    logic [TEX_W-1:0]         r_in_tex;
    logic                     r_in_flip;
    logic signed [DIR_W-1:0]  r_in_dir;
    logic [FRAC_W-1:0]        r_in_p16;
    logic [DIST_W-1:0]        r_in_dist;
    logic [LH_W-1:0]          r_in_lh;
    logic [OFS_W-1:0]         r_in_ofs;
    logic [ROW_W-1:0]         r_in_rs;
    logic [ROW_W-1:0]         r_in_re;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_in_column <= i_column;
            r_in_tex    <= in_tex;
            r_in_flip   <= in_flip;
            r_in_dir    <= i_side ? i_ray_dir_x : i_ray_dir_y;
            r_in_p16    <= i_side ? i_player_x[FRAC_W-1:0] : i_player_y[FRAC_W-1:0];
            r_in_dist   <= i_wall_dist;
            r_in_lh     <= in_lh;
            r_in_ofs    <= in_ofs;
            r_in_rs     <= i_row_start;
            r_in_re     <= (i_row_end > SCREEN_ROWS) ? SCREEN_ROWS : i_row_end;
        end
    end

    // Hit position along the wall and texture column
    logic signed [DIST_W+DIR_W:0] wall_mult;
    logic [31:0]                  wall_sum;
    logic [31:0]                  r_wall_lo;
    logic [FRAC_W-1:0]            r_frac;
    logic [FRAC_W+SIZE_W-1:0]     r_tx_prod;
    logic [SIZE_W-1:0]            tx_raw;
    logic [SIZE_W-1:0]            tx_flip;
    logic [TXL_W-1:0]             tx_final;

    assign wall_mult = $signed({1'b0, r_in_dist}) * r_in_dir;
    assign wall_sum  = r_wall_lo + {r_in_p16, 16'b0};
    assign tx_raw    = r_tx_prod[FRAC_W+SIZE_W-1:FRAC_W];
    assign tx_flip   = tw - tx_raw - SIZE_W'(1);
    assign tx_final  = r_in_flip ? tx_flip[TXL_W-1:0] : tx_raw[TXL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.su_mul) begin
            r_wall_lo <= wall_mult[31:0];
        end
        if (i_ctl.su_frac) begin
            r_frac <= wall_sum[31:16];
        end
        if (i_ctl.su_tx) begin
            r_tx_prod <= (FRAC_W+SIZE_W)'(r_frac) * (FRAC_W+SIZE_W)'(tw);
        end
    end

    // Shared divider and its operand select
    logic [DIV_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_quot;
    logic [DVS_W-1:0] div_rem;

    logic [STEP_W-1:0] r_row_step;
    logic [BIG_W-1:0]  r_big;
    logic [POS_W-1:0]  r_pos;
    logic [STEP_W-1:0] r_sum;
    logic [TXL_W-1:0]  pos_hi;

    assign pos_hi = r_pos[POS_W-1:FRAC_W];

    always_comb begin
        case (i_ctl.div_sel)
            DIV_STEP: begin
                div_dividend = {th, 16'b0};
                div_divisor  = r_in_lh;
            end
            DIV_POS: begin
                div_dividend = r_big[BIG_W-1:FRAC_W];
                div_divisor  = DVS_W'(th);
            end
            DIV_TEX: begin
                div_dividend = DIV_W'(pos_hi);
                div_divisor  = DVS_W'(th);
            end
            DIV_SUM: begin
                div_dividend = DIV_W'(r_sum[STEP_W-1:FRAC_W]);
                div_divisor  = DVS_W'(th);
            end
            default: begin
                div_dividend = {th, 16'b0};
                div_divisor  = r_in_lh;
            end
        endcase
    end

    wcm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Row wrap arithmetic
    logic [STEP_W-1:0] modulus;
    logic              tex_fast;
    logic              sum_lt;
    logic              sum_lt2;
    logic [STEP_W-1:0] sum_sub;

    assign modulus  = {th, 16'b0};
    assign tex_fast = ({1'b0, pos_hi} < th);
    assign sum_lt   = (r_sum < modulus);
    assign sum_lt2  = ({1'b0, r_sum} < {modulus, 1'b0});
    assign sum_sub  = r_sum - modulus;

    // Held column state
    logic [COL_W-1:0] r_held_column;
    logic [TEX_W-1:0] r_held_tex;
    logic [TXL_W-1:0] r_held_txc;
    logic [TXL_W-1:0] r_tex_row;
    logic [ROW_W-1:0] r_cur;
    logic [ROW_W-1:0] r_end;
    logic [ROW_W-1:0] cur_inc;

    assign cur_inc = r_cur + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_ctl.step_cap) begin
            r_row_step <= div_quot;
        end
        if (i_ctl.ofs_mul) begin
            r_big <= BIG_W'(r_in_ofs) * BIG_W'(r_row_step);
        end
        if (i_ctl.row_sum) begin
            r_sum <= STEP_W'(r_pos) + r_row_step;
        end
        if (i_ctl.tex_cap) begin
            r_tex_row <= tex_fast ? pos_hi : div_rem[TXL_W-1:0];
        end
        if (i_ctl.su_commit) begin
            r_pos         <= {div_rem[TXL_W-1:0], r_big[FRAC_W-1:0]};
            r_held_column <= r_in_column;
            r_held_tex    <= r_in_tex;
            r_held_txc    <= tx_final;
        end else if (i_ctl.pos_red) begin
            if (sum_lt) begin
                r_pos <= r_sum[POS_W-1:0];
            end else if (sum_lt2) begin
                r_pos <= sum_sub[POS_W-1:0];
            end else begin
                r_pos <= {div_rem[TXL_W-1:0], r_sum[FRAC_W-1:0]};
            end
        end
    end

    // Row span counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
            r_end <= '0;
        end else if (i_ctl.su_commit) begin
            r_cur <= r_in_rs;
            r_end <= r_in_re;
        end else if (i_ctl.out_load) begin
            r_cur <= cur_inc;
        end
    end

    // Output register
    logic             r_o_valid;
    logic [COL_W-1:0] r_o_column;
    logic [OROW_W-1:0] r_o_row;
    logic [TEX_W-1:0] r_o_tex;
    logic [TXL_W-1:0] r_o_txc;
    logic [TXL_W-1:0] r_o_txr;
    logic             r_o_last;
    logic             out_free;

    assign out_free = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_o_column <= r_held_column;
            r_o_row    <= r_cur[OROW_W-1:0];
            r_o_tex    <= r_held_tex;
            r_o_txc    <= r_held_txc;
            r_o_txr    <= r_tex_row;
            r_o_last   <= (cur_inc == r_end);
        end
    end

    assign o_valid         = r_o_valid;
    assign o_out_column    = r_o_column;
    assign o_out_row       = r_o_row;
    assign o_texture_index = r_o_tex;
    assign o_texel_column  = r_o_txc;
    assign o_texel_row     = r_o_txr;
    assign o_last          = r_o_last;

    // Status back to the controller
    assign o_status.div_done    = div_done;
    assign o_status.span_active = (r_cur < r_end);
    assign o_status.tex_fast    = tex_fast;
    assign o_status.red_fast    = sum_lt2;
    assign o_status.out_free    = out_free;

endmodule

@@ sv/wcm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcm_ctrl
// Sequencer of the texture mapper: walks column set-up and row items through
// the datapath and the shared divider.
// ----------------------------------------------------------------------------
module wcm_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_item_cmd,
    output logic                  o_stall,
    output wcm_pkg::t_dp_cmd      o_ctl,
    input  wcm_pkg::t_dp_status   i_status
);
    import wcm_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_SU_MUL    = 13'b0000000000010,
        S_SU_FRAC   = 13'b0000000000100,
        S_SU_TX     = 13'b0000000001000,
        S_SU_WSTEP  = 13'b0000000010000,
        S_SU_OFS    = 13'b0000000100000,
        S_SU_PSTART = 13'b0000001000000,
        S_SU_WPOS   = 13'b0000010000000,
        S_R_TEX     = 13'b0000100000000,
        S_R_WTEX    = 13'b0001000000000,
        S_R_RED     = 13'b0010000000000,
        S_R_WSUM    = 13'b0100000000000,
        S_R_OUT     = 13'b1000000000000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        ctl         = '0;
        ctl.div_sel = DIV_STEP;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    ctl.load_in = 1'b1;
                    if (i_item_cmd == CMD_SETUP) begin
                        n_state = S_SU_MUL;
                    end else if (i_status.span_active) begin
                        n_state = S_R_TEX;
                    end
                end
            end
            // column set-up: step division runs beside the texel column math
            S_SU_MUL: begin
                ctl.su_mul    = 1'b1;
                ctl.div_start = 1'b1;
                ctl.div_sel   = DIV_STEP;
                n_state       = S_SU_FRAC;
            end
            S_SU_FRAC: begin
                ctl.su_frac = 1'b1;
                n_state     = S_SU_TX;
            end
            S_SU_TX: begin
                ctl.su_tx = 1'b1;
                n_state   = S_SU_WSTEP;
            end
            S_SU_WSTEP: begin
                if (i_status.div_done) begin
                    ctl.step_cap = 1'b1;
                    n_state      = S_SU_OFS;
                end
            end
            S_SU_OFS: begin
                ctl.ofs_mul = 1'b1;
                n_state     = S_SU_PSTART;
            end
            S_SU_PSTART: begin
                ctl.div_start = 1'b1;
                ctl.div_sel   = DIV_POS;
                n_state       = S_SU_WPOS;
            end
            S_SU_WPOS: begin
                if (i_status.div_done) begin
                    ctl.su_commit = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            // row item: texel row, then advance and wrap the position
            S_R_TEX: begin
                ctl.row_sum = 1'b1;
                if (i_status.tex_fast) begin
                    ctl.tex_cap = 1'b1;
                    n_state     = S_R_RED;
                end else begin
                    ctl.div_start = 1'b1;
                    ctl.div_sel   = DIV_TEX;
                    n_state       = S_R_WTEX;
                end
            end
            S_R_WTEX: begin
                if (i_status.div_done) begin
                    ctl.tex_cap = 1'b1;
                    n_state     = S_R_RED;
                end
            end
            S_R_RED: begin
                if (i_status.red_fast) begin
                    ctl.pos_red = 1'b1;
                    n_state     = S_R_OUT;
                end else begin
                    ctl.div_start = 1'b1;
                    ctl.div_sel   = DIV_SUM;
                    n_state       = S_R_WSUM;
                end
            end
            S_R_WSUM: begin
                if (i_status.div_done) begin
                    ctl.pos_red = 1'b1;
                    n_state     = S_R_OUT;
                end
            end
            S_R_OUT: begin
                if (i_status.out_free) begin
                    ctl.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ctl   = ctl;
    assign o_stall = (r_state != S_IDLE);

endmodule

@@ sv/wall_column_texture_mapper.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wall_column_texture_mapper
// Texel addressing for one wall column of a grid raycaster, Q8.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) takes column set-up items (cmd 0) and
//   row items (cmd 1); output channel (o_valid / i_stall) returns one texel
//   address per row item while a span is active. Configuration writes
//   (i_cfg_we, i_cfg_idx, i_cfg_data) set texture width and height.
//   Set-up gives no transfer; most of its time goes to two passes of the
//   shared one-bit-per-cycle divider: row step, start position modulo height.
//   A row item steps through the texel row state and the position wrap
//   state, and its result is then loaded into the output register.
//   When a texture height change left the position outside the texture, or
//   the step carries it past twice the height, one or two extra divider
//   passes are added. Row items outside the span are taken without a stall
//   and give no transfer.
//   Items are worked one at a time; o_stall is high while one is in flight.
//   A finished result waits in the output register while the receiver
//   stalls; the next item is still accepted and its result held back until
//   the register drains.
//   Reset restores 64x64 textures and clears the span, so rows give nothing
//   until the first set-up.
// ----------------------------------------------------------------------------
module wall_column_texture_mapper (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [wcm_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [wcm_pkg::SIZE_W-1:0]           i_cfg_data,
    // input channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_cmd,
    input  logic [wcm_pkg::COL_W-1:0]            i_column,
    input  logic                                 i_side,
    input  logic                                 i_is_door,
    input  logic signed [wcm_pkg::DIR_W-1:0]     i_ray_dir_x,
    input  logic signed [wcm_pkg::DIR_W-1:0]     i_ray_dir_y,
    input  logic [wcm_pkg::DIST_W-1:0]           i_wall_dist,
    input  logic [wcm_pkg::LH_W-1:0]             i_line_height,
    input  logic [wcm_pkg::ROW_W-1:0]            i_row_start,
    input  logic [wcm_pkg::ROW_W-1:0]            i_row_end,
    input  logic [wcm_pkg::POSIN_W-1:0]          i_player_x,
    input  logic [wcm_pkg::POSIN_W-1:0]          i_player_y,
    // output channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [wcm_pkg::COL_W-1:0]            o_out_column,
    output logic [wcm_pkg::OROW_W-1:0]           o_out_row,
    output logic [wcm_pkg::TEX_W-1:0]            o_texture_index,
    output logic [wcm_pkg::TXL_W-1:0]            o_texel_column,
    output logic [wcm_pkg::TXL_W-1:0]            o_texel_row,
    output logic                                 o_last
);
    import wcm_pkg::*;

    t_dp_cmd    ctl;
    t_dp_status status;

    // Sequencer
    wcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_item_cmd (i_cmd),
        .o_stall    (o_stall),
        .o_ctl      (ctl),
        .i_status   (status)
    );

    // Datapath
    wcm_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_status        (status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_column        (i_column),
        .i_side          (i_side),
        .i_is_door       (i_is_door),
        .i_ray_dir_x     (i_ray_dir_x),
        .i_ray_dir_y     (i_ray_dir_y),
        .i_wall_dist     (i_wall_dist),
        .i_line_height   (i_line_height),
        .i_row_start     (i_row_start),
        .i_row_end       (i_row_end),
        .i_player_x      (i_player_x),
        .i_player_y      (i_player_y),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_out_column    (o_out_column),
        .o_out_row       (o_out_row),
        .o_texture_index (o_texture_index),
        .o_texel_column  (o_texel_column),
        .o_texel_row     (o_texel_row),
        .o_last          (o_last)
    );

endmodule
